[rtl/mte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mte_pkg;

    // Field widths
    localparam int POS_W  = 13;
    localparam int RATE_W = 14;
    localparam int TURN_W = 19;
    localparam int ABS_W  = 32;
    localparam int ANG_W  = 33;

    // Mode flag codes
    localparam logic CMD_CAPTURE = 1'b0;
    localparam logic CMD_TRACK   = 1'b1;

    // Unwrap and saturation limits
    localparam int COUNTS_PER_TURN = 8192;
    localparam int WRAP_LIMIT      = 6500;
    localparam int TURN_MAX        = 262143;
    localparam int TURN_MIN        = -262144;

    // Rate ring
    localparam int RING_DEPTH = 8;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W      = RATE_W + $clog2(RING_DEPTH);
    localparam int SUM_LIM    = WRAP_LIMIT * RING_DEPTH;

    // Reciprocal for the ring average: exact for any SUM_W-bit magnitude
    localparam int DIV_K = SUM_W + $clog2(RING_DEPTH);
    localparam longint unsigned DIV_RECIP_L =
        ((64'd1 << DIV_K) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [DIV_K:0] DIV_RECIP = (DIV_K + 1)'(DIV_RECIP_L);

endpackage

`default_nettype wire

[rtl/mte_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mte_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [ADDR_W-1:0]       i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic [ADDR_W-1:0]       i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/multiturn_encoder_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | valid   | ready   | words
// ---------+---------+---------+-------------------------------------------------------
// sample   | i_valid | o_ready | i_cmd, i_position
// result   | o_valid | i_ready | o_absolute_count, o_angle_counts, o_raw_rate,
//          |         |         | o_filtered_rate, o_turn_count
//
// One sample per cycle unless stalled; results pass stage one and the output register.
// The oldest ring entry is read ahead from the rate RAM at the next ring index,
// and is forwarded when that entry is written in the same cycle.
// Reset clears the state registers and the ring valid bits at once; no clearing pass.
// A stalled result holds in the output register while one more sample is taken.

module multiturn_encoder_tracker_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_cmd,
    input  wire logic [mte_pkg::POS_W-1:0]         i_position,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [mte_pkg::ABS_W-1:0]       o_absolute_count,
    output logic signed [mte_pkg::ANG_W-1:0]       o_angle_counts,
    output logic signed [mte_pkg::RATE_W-1:0]      o_raw_rate,
    output logic signed [mte_pkg::RATE_W-1:0]      o_filtered_rate,
    output logic signed [mte_pkg::TURN_W-1:0]      o_turn_count
);

    localparam int POS_W  = mte_pkg::POS_W;
    localparam int RATE_W = mte_pkg::RATE_W;
    localparam int TURN_W = mte_pkg::TURN_W;
    localparam int ABS_W  = mte_pkg::ABS_W;
    localparam int ANG_W  = mte_pkg::ANG_W;
    localparam int IDX_W  = mte_pkg::IDX_W;
    localparam int SUM_W  = mte_pkg::SUM_W;
    localparam int DIV_K  = mte_pkg::DIV_K;
    localparam int DEPTH  = mte_pkg::RING_DEPTH;

    // Tracking state
    logic        [POS_W-1:0]  r_prev, n_prev;
    logic        [POS_W-1:0]  r_bias, n_bias;
    logic signed [TURN_W-1:0] r_turns, n_turns;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic        [IDX_W-1:0]  r_idx, n_idx;
    logic        [DEPTH-1:0]  r_valid, n_valid;

    // Read-ahead of the oldest ring entry
    logic                     r_fwd;
    logic signed [RATE_W-1:0] r_fwd_data;
    logic                     r_rdv;
    logic        [RATE_W-1:0] rd_data;
    logic signed [RATE_W-1:0] old_rate;

    // Pipeline
    logic                     accept;
    logic                     track;
    logic                     s2_load;
    logic                     r_s1_valid;
    logic signed [ABS_W-1:0]  r_s1_abs, n_abs;
    logic signed [ANG_W-1:0]  r_s1_angle, n_angle;
    logic signed [RATE_W-1:0] r_s1_rate, n_rate;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic signed [TURN_W-1:0] r_s1_turns;
    logic                     r_out_valid;

    // Unwrap and divide helpers
    logic signed [RATE_W-1:0] diff;
    logic signed [RATE_W:0]   diff_x;
    logic signed [RATE_W:0]   pos_off;
    logic        [SUM_W-1:0]  mag;
    logic        [SUM_W+DIV_K:0] prod;
    logic        [RATE_W-1:0] quot;
    logic signed [RATE_W-1:0] n_filt;

    assign track   = (i_cmd == mte_pkg::CMD_TRACK);
    assign s2_load = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s2_load;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    // Pick the oldest ring entry: forwarded, stored, or zero if never written
    assign old_rate = r_fwd ? r_fwd_data : (r_rdv ? $signed(rd_data) : '0);

    // Unwrap the difference and update the state
    always_comb begin
        diff    = $signed({1'b0, i_position}) - $signed({1'b0, r_prev});
        diff_x  = {diff[RATE_W-1], diff};
        n_prev  = r_prev;
        n_bias  = r_bias;
        n_turns = r_turns;
        n_sum   = r_sum;
        n_idx   = r_idx;
        n_valid = r_valid;
        n_rate  = '0;
        if (accept && !track) begin
            n_bias = i_position;
            n_prev = i_position;
        end else if (accept) begin
            n_prev = i_position;
            if (diff < -mte_pkg::WRAP_LIMIT) begin
                n_rate = RATE_W'(diff_x + (RATE_W + 1)'(mte_pkg::COUNTS_PER_TURN));
                if (r_turns < mte_pkg::TURN_MAX) begin
                    n_turns = r_turns + TURN_W'(1);
                end
            end else if (diff > mte_pkg::WRAP_LIMIT) begin
                n_rate = RATE_W'(diff_x - (RATE_W + 1)'(mte_pkg::COUNTS_PER_TURN));
                if (r_turns > mte_pkg::TURN_MIN) begin
                    n_turns = r_turns - TURN_W'(1);
                end
            end else begin
                n_rate = diff;
            end
            n_sum          = r_sum - SUM_W'(old_rate) + SUM_W'(n_rate);
            n_valid[r_idx] = 1'b1;
            n_idx          = (r_idx == IDX_W'(DEPTH - 1)) ? '0 : r_idx + IDX_W'(1);
        end
    end

    // Build the position words
    always_comb begin
        pos_off = track ? ($signed({2'b00, i_position}) - $signed({2'b00, r_bias})) : '0;
        n_abs   = track ? $signed({n_turns, i_position})
                        : $signed(ABS_W'(i_position));
        n_angle = $signed({n_turns[TURN_W-1], n_turns, {POS_W{1'b0}}})
                + ANG_W'(pos_off);
    end

    // Rate ring storage
    mte_ram #(
        .WIDTH (RATE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && track),
        .i_waddr (r_idx),
        .i_wdata (n_rate),
        .i_raddr (n_idx),
        .o_rdata (rd_data)
    );

    // Hold the tracking state and the read-ahead flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_bias  <= '0;
            r_turns <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
            r_valid <= '0;
            r_fwd   <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_bias  <= n_bias;
            r_turns <= n_turns;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            r_valid <= n_valid;
            r_fwd   <= accept && track && (r_idx == n_idx);
            r_rdv   <= r_valid[n_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= n_rate;
    end

    // Stage one: hold the word until the output register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s2_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_abs   <= n_abs;
            r_s1_angle <= n_angle;
            r_s1_rate  <= n_rate;
            r_s1_sum   <= n_sum;
            r_s1_turns <= n_turns;
        end
    end

    // Average the ring: magnitude times reciprocal, sign restored
    always_comb begin
        mag    = r_s1_sum[SUM_W-1] ? SUM_W'(-r_s1_sum) : SUM_W'(r_s1_sum);
        prod   = (SUM_W + DIV_K + 1)'(mag) * (SUM_W + DIV_K + 1)'(mte_pkg::DIV_RECIP);
        quot   = RATE_W'(prod >> DIV_K);
        n_filt = r_s1_sum[SUM_W-1] ? -$signed(quot) : $signed(quot);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            o_absolute_count <= r_s1_abs;
            o_angle_counts   <= r_s1_angle;
            o_raw_rate       <= r_s1_rate;
            o_filtered_rate  <= n_filt;
            o_turn_count     <= r_s1_turns;
        end
    end

    // Running sum stays within what the ring can hold
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum <= mte_pkg::SUM_LIM) && (r_sum >= -mte_pkg::SUM_LIM))
        else $error("ring sum out of range");

    // Turn count and sum move only when a sample is taken
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_turns) && $stable(r_sum) && $stable(r_idx))
        else $error("tracking state changed without a sample");

    // A stalled stage-one word keeps its place
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_load |=> r_s1_valid && $stable(r_s1_sum))
        else $error("stage-one word lost during stall");

    // Forwarding only follows a track sample
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> $past(accept) && $past(track))
        else $error("forward without a ring write");

endmodule

`default_nettype wire

[dv/mte_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the encoder tracker, predicts every result word
// from the accepted samples and compares what comes out, oldest first.
module mte_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic                              i_cmd,
    input  wire logic [mte_pkg::POS_W-1:0]         i_position,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic signed [mte_pkg::ABS_W-1:0]  i_absolute_count,
    input  wire logic signed [mte_pkg::ANG_W-1:0]  i_angle_counts,
    input  wire logic signed [mte_pkg::RATE_W-1:0] i_raw_rate,
    input  wire logic signed [mte_pkg::RATE_W-1:0] i_filtered_rate,
    input  wire logic signed [mte_pkg::TURN_W-1:0] i_turn_count,
    output int                                     o_mismatches,
    output int                                     o_pending
);

    typedef struct packed {
        logic signed [mte_pkg::ABS_W-1:0]  absolute_count;
        logic signed [mte_pkg::ANG_W-1:0]  angle_counts;
        logic signed [mte_pkg::RATE_W-1:0] raw_rate;
        logic signed [mte_pkg::RATE_W-1:0] filtered_rate;
        logic signed [mte_pkg::TURN_W-1:0] turn_count;
    } t_track_report;

    // Predicted tracker state
    logic [mte_pkg::POS_W-1:0] last_reading;
    logic [mte_pkg::POS_W-1:0] zero_bias;
    int                        turn_total;
    int                        rate_hist [mte_pkg::RING_DEPTH];
    int                        hist_slot;
    int                        hist_sum;

    t_track_report             reports_due [$];
    int                        bad_reports = 0;

    assign o_mismatches = bad_reports;

    // Unwrap one sample, update the rate history and form the report
    task automatic unwrap_sample(input logic cmd, input logic [mte_pkg::POS_W-1:0] pos,
                                 output t_track_report rep);
        int     diff;
        int     rate;
        longint absolute;
        longint angle;
        rate = 0;
        if (cmd == mte_pkg::CMD_CAPTURE) begin
            zero_bias    = pos;
            last_reading = pos;
            absolute     = longint'(pos);
        end else begin
            diff = int'(pos) - int'(last_reading);
            if (diff < -mte_pkg::WRAP_LIMIT) begin
                rate = diff + mte_pkg::COUNTS_PER_TURN;
                if (turn_total < mte_pkg::TURN_MAX) turn_total++;
            end else if (diff > mte_pkg::WRAP_LIMIT) begin
                rate = diff - mte_pkg::COUNTS_PER_TURN;
                if (turn_total > mte_pkg::TURN_MIN) turn_total--;
            end else begin
                rate = diff;
            end
            last_reading = pos;
            hist_sum = hist_sum - rate_hist[hist_slot] + rate;
            rate_hist[hist_slot] = rate;
            hist_slot = (hist_slot + 1) % mte_pkg::RING_DEPTH;
            absolute = longint'(pos) + longint'(turn_total) * mte_pkg::COUNTS_PER_TURN;
        end
        angle = longint'(pos) - longint'(zero_bias)
              + longint'(turn_total) * mte_pkg::COUNTS_PER_TURN;
        rep.absolute_count = absolute[mte_pkg::ABS_W-1:0];
        rep.angle_counts   = angle[mte_pkg::ANG_W-1:0];
        rep.raw_rate       = rate[mte_pkg::RATE_W-1:0];
        rep.filtered_rate  = mte_pkg::RATE_W'(hist_sum / mte_pkg::RING_DEPTH);
        rep.turn_count     = turn_total[mte_pkg::TURN_W-1:0];
    endtask

    // Report one differing field
    function automatic void show_field(input string field, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_track_report want;
        t_track_report got;
        if (!i_rst_n) begin
            last_reading = '0;
            zero_bias    = '0;
            turn_total   = 0;
            hist_slot    = 0;
            hist_sum     = 0;
            for (int k = 0; k < mte_pkg::RING_DEPTH; k++) rate_hist[k] = 0;
            reports_due.delete();
        end else begin
            // Retire the oldest expectation against the word just taken
            if (i_out_valid && i_out_ready) begin
                got = '{i_absolute_count, i_angle_counts, i_raw_rate,
                        i_filtered_rate, i_turn_count};
                if (reports_due.size() == 0) begin
                    bad_reports++;
                    $display("%0t: result word expected none, got absolute %0d",
                             $time, i_absolute_count);
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want) begin
                        bad_reports++;
                        show_field("absolute_count", want.absolute_count,
                                   got.absolute_count);
                        show_field("angle_counts", want.angle_counts, got.angle_counts);
                        show_field("raw_rate", want.raw_rate, got.raw_rate);
                        show_field("filtered_rate", want.filtered_rate,
                                   got.filtered_rate);
                        show_field("turn_count", want.turn_count, got.turn_count);
                    end
                end
            end
            // Predict the word for each sample taken
            if (i_in_valid && i_in_ready) begin
                unwrap_sample(i_cmd, i_position, want);
                reports_due.push_back(want);
            end
        end
        o_pending <= reports_due.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_valid    = 1'b0;
    logic                              i_cmd      = mte_pkg::CMD_CAPTURE;
    logic [mte_pkg::POS_W-1:0]         i_position = '0;
    logic                              i_ready    = 1'b0;
    logic                              o_ready;
    logic                              o_valid;
    logic signed [mte_pkg::ABS_W-1:0]  o_absolute_count;
    logic signed [mte_pkg::ANG_W-1:0]  o_angle_counts;
    logic signed [mte_pkg::RATE_W-1:0] o_raw_rate;
    logic signed [mte_pkg::RATE_W-1:0] o_filtered_rate;
    logic signed [mte_pkg::TURN_W-1:0] o_turn_count;
    int                                mismatches;
    int                                pending;

    int                                send_idle_pct  = 0;
    int                                recv_stall_pct = 0;
    logic [mte_pkg::POS_W-1:0]         last_sent      = '0;

    multiturn_encoder_tracker_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_absolute_count (o_absolute_count),
        .o_angle_counts   (o_angle_counts),
        .o_raw_rate       (o_raw_rate),
        .o_filtered_rate  (o_filtered_rate),
        .o_turn_count     (o_turn_count)
    );

    mte_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_absolute_count (o_absolute_count),
        .i_angle_counts   (o_angle_counts),
        .i_raw_rate       (o_raw_rate),
        .i_filtered_rate  (o_filtered_rate),
        .i_turn_count     (o_turn_count),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at the current rate
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one sample word and hold it until it is taken
    task automatic send_word(input logic cmd, input logic [mte_pkg::POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        last_sent  = pos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Hold off the sample side until every result word has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Small steps from the last position, with wrap-limit steps, jumps, extremes and captures
    task automatic send_random();
        int                        pick;
        int                        step;
        int                        target;
        logic                      cmd;
        logic [mte_pkg::POS_W-1:0] pos;
        pick = $urandom_range(99);
        cmd  = mte_pkg::CMD_TRACK;
        pos  = mte_pkg::POS_W'($urandom);
        if (pick < 8) begin
            cmd = mte_pkg::CMD_CAPTURE;
        end else if (pick < 50) begin
            step = $urandom_range(600) - 300;
            pos  = mte_pkg::POS_W'(int'(last_sent) + step);
        end else if (pick < 70) begin
            step = mte_pkg::WRAP_LIMIT - 1 + $urandom_range(2);
            if ($urandom_range(1)) step = -step;
            target = int'(last_sent) + step;
            if (target < 0 || target >= mte_pkg::COUNTS_PER_TURN) begin
                target = int'(last_sent) - step;
            end
            pos = mte_pkg::POS_W'(target);
        end else if (pick >= 85) begin
            pos = $urandom_range(1) ? '1 : '0;
        end
        send_word(cmd, pos);
    endtask

    initial begin : stimulus
        int phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, wrap limits either side, captures
        send_word(mte_pkg::CMD_CAPTURE, 13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_CAPTURE, 13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd1691);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd1690);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd1692);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd6500);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd6501);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_CAPTURE, 13'd4096);
        send_word(mte_pkg::CMD_TRACK,   13'd5461);
        send_word(mte_pkg::CMD_TRACK,   13'd2730);
        send_word(mte_pkg::CMD_CAPTURE, 13'd2730);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        send_word(mte_pkg::CMD_TRACK,   13'd8191);
        send_word(mte_pkg::CMD_TRACK,   13'd0);
        drain();

        // Random words under each idling pattern
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            repeat (375) send_random();
        end
        drain();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Give up well past the slowest correct run
    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
